// File: sv/mrpt_pkg.sv
package mrpt_pkg;

  // Width of the raw witness word and the width of its step counter.
  localparam int unsigned RAW_W   = 31;
  localparam int unsigned RAW_CW  = 5;

  // Smallest number that takes a full round; smaller ones are decided at once.
  localparam int unsigned FIRST_FULL = 5;

  // Operand choice of the shared modular multiplier.
  typedef enum logic [1:0] {
    MUL_AB = 2'd0,  // acc * base, result to acc
    MUL_BB = 2'd1,  // base * base, result to base
    MUL_AA = 2'd2   // acc * acc, result to acc
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_step;
    logic     set_base;
    logic     exp_shift;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     mul_step;
    logic     mul_wb;
  } dp_cmd_t;

  typedef struct packed {
    logic small_num;
    logic small_comp;
    logic e_zero;
    logic e_lsb;
    logic acc_one;
    logic acc_nm1;
  } dp_status_t;

endpackage

// File: sv/mrpt_dp.sv
module mrpt_dp import mrpt_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = 63
) (
  input  logic                    clk_i,
  input  logic [NUMBER_WIDTH-1:0] number_i,
  input  logic [RAW_W-1:0]        witness_raw_i,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o
);

  localparam int unsigned W = NUMBER_WIDTH;

  logic [W-1:0]     n_q, rem_q, e_q, acc_q, base_q, mx_q, my_q, macc_q;
  logic [W-1:0]     n_d, rem_d, e_d, acc_d, base_d, mx_d, my_d, macc_d;
  logic [RAW_W-1:0] raw_q, raw_d;
  mul_sel_e         dest_q, dest_d;

  logic [W:0]   div_t;
  logic [W-1:0] div_dvs;
  logic [W-1:0] op_a, op_b;

  // Exact (x + y) mod n for x, y < n, with one guard bit on the sum.
  function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] n);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, n}) begin
      s = s - {1'b0, n};
    end
    return s[W-1:0];
  endfunction

  assign div_t   = {rem_q, raw_q[RAW_W-1]};
  assign div_dvs = n_q - W'(4);

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_AB: begin
        op_a = acc_q;
        op_b = base_q;
      end
      MUL_BB: begin
        op_a = base_q;
        op_b = base_q;
      end
      default: begin
        op_a = acc_q;
        op_b = acc_q;
      end
    endcase
  end

  always_comb begin
    n_d    = n_q;
    rem_d  = rem_q;
    raw_d  = raw_q;
    e_d    = e_q;
    acc_d  = acc_q;
    base_d = base_q;
    mx_d   = mx_q;
    my_d   = my_q;
    macc_d = macc_q;
    dest_d = dest_q;
    if (cmd_i.load) begin
      n_d   = number_i;
      raw_d = witness_raw_i;
      rem_d = '0;
      e_d   = number_i - W'(1);
    end
    if (cmd_i.div_step) begin
      // Restoring division, one quotient bit per cycle; only the remainder is kept.
      if (div_t >= {1'b0, div_dvs}) begin
        rem_d = W'(div_t - {1'b0, div_dvs});
      end else begin
        rem_d = div_t[W-1:0];
      end
      raw_d = {raw_q[RAW_W-2:0], 1'b0};
    end
    if (cmd_i.set_base) begin
      base_d = rem_q + W'(2);
      acc_d  = W'(1);
    end
    if (cmd_i.exp_shift) begin
      e_d = e_q >> 1;
    end
    if (cmd_i.mul_start) begin
      mx_d   = op_a;
      my_d   = op_b;
      macc_d = '0;
      dest_d = cmd_i.mul_sel;
    end
    if (cmd_i.mul_step) begin
      if (my_q[0]) begin
        macc_d = mod_add(macc_q, mx_q, n_q);
      end
      mx_d = mod_add(mx_q, mx_q, n_q);
      my_d = my_q >> 1;
    end
    if (cmd_i.mul_wb) begin
      if (dest_q == MUL_BB) begin
        base_d = macc_q;
      end else begin
        acc_d = macc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    rem_q  <= rem_d;
    raw_q  <= raw_d;
    e_q    <= e_d;
    acc_q  <= acc_d;
    base_q <= base_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    macc_q <= macc_d;
    dest_q <= dest_d;
  end

  assign status_o.small_num  = (n_q < W'(FIRST_FULL));
  assign status_o.small_comp = !((n_q == W'(2)) || (n_q == W'(3)));
  assign status_o.e_zero     = (e_q == '0);
  assign status_o.e_lsb      = e_q[0];
  assign status_o.acc_one    = (acc_q == W'(1));
  assign status_o.acc_nm1    = (acc_q == (n_q - W'(1)));

endmodule

// File: sv/mrpt_ctrl.sv
module mrpt_ctrl import mrpt_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       last_round_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       probably_prime_o,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  localparam int unsigned W    = NUMBER_WIDTH;
  localparam int unsigned CW   = $clog2(W + 1);
  localparam int unsigned CNTW = (CW > RAW_CW) ? CW : RAW_CW;
  localparam int unsigned RW   = $clog2(W);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_DIV      = 4'd2;
  localparam logic [3:0] S_SETB     = 4'd3;
  localparam logic [3:0] S_STRIP    = 4'd4;
  localparam logic [3:0] S_POW_CHK  = 4'd5;
  localparam logic [3:0] S_POW_SQ   = 4'd6;
  localparam logic [3:0] S_POW_SHFT = 4'd7;
  localparam logic [3:0] S_MUL      = 4'd8;
  localparam logic [3:0] S_MUL_WB   = 4'd9;
  localparam logic [3:0] S_TEST1    = 4'd10;
  localparam logic [3:0] S_LOOP     = 4'd11;
  localparam logic [3:0] S_LOOP_CHK = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0]    state_q, state_d, ret_q, ret_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] r_q, r_d, j_q, j_d;
  logic          last_q, last_d;
  logic          comp_q, comp_d;
  logic          seen_q, seen_d;
  logic          ov_q, ov_d;
  logic          pp_q, pp_d;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cnt_d   = cnt_q;
    r_d     = r_q;
    j_d     = j_q;
    last_d  = last_q;
    comp_d  = comp_q;
    seen_d  = seen_q;
    ov_d    = ov_q && out_stall_i;
    pp_d    = pp_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_AB;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          last_d     = last_round_i;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cnt_d = '0;
        r_d   = '0;
        if (status_i.small_num) begin
          comp_d  = status_i.small_comp;
          state_d = S_DONE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(RAW_W - 1)) begin
          state_d = S_SETB;
        end
      end
      S_SETB: begin
        cmd_o.set_base = 1'b1;
        state_d = S_STRIP;
      end
      S_STRIP: begin
        if (status_i.e_lsb) begin
          state_d = S_POW_CHK;
        end else begin
          cmd_o.exp_shift = 1'b1;
          r_d = r_q + RW'(1);
        end
      end
      S_POW_CHK: begin
        if (status_i.e_zero) begin
          state_d = S_TEST1;
        end else if (status_i.e_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_AB;
          cnt_d   = '0;
          ret_d   = S_POW_SQ;
          state_d = S_MUL;
        end else begin
          state_d = S_POW_SQ;
        end
      end
      S_POW_SQ: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_BB;
        cnt_d   = '0;
        ret_d   = S_POW_SHFT;
        state_d = S_MUL;
      end
      S_POW_SHFT: begin
        cmd_o.exp_shift = 1'b1;
        state_d = S_POW_CHK;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(W - 1)) begin
          state_d = S_MUL_WB;
        end
      end
      S_MUL_WB: begin
        cmd_o.mul_wb = 1'b1;
        state_d = ret_q;
      end
      S_TEST1: begin
        j_d = '0;
        if (status_i.acc_one) begin
          comp_d  = 1'b0;
          state_d = S_DONE;
        end else begin
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (j_q == r_q) begin
          comp_d  = 1'b1;
          state_d = S_DONE;
        end else if (status_i.acc_nm1) begin
          comp_d  = 1'b0;
          state_d = S_DONE;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_AA;
          cnt_d   = '0;
          ret_d   = S_LOOP_CHK;
          state_d = S_MUL;
        end
      end
      S_LOOP_CHK: begin
        if (status_i.acc_one) begin
          comp_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          j_d     = j_q + RW'(1);
          state_d = S_LOOP;
        end
      end
      S_DONE: begin
        if (!last_q) begin
          seen_d  = seen_q || comp_q;
          state_d = S_IDLE;
        end else if (!(ov_q && out_stall_i)) begin
          ov_d    = 1'b1;
          pp_d    = !(seen_q || comp_q);
          seen_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      cnt_q   <= '0;
      r_q     <= '0;
      j_q     <= '0;
      last_q  <= 1'b0;
      comp_q  <= 1'b0;
      seen_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      r_q     <= r_d;
      j_q     <= j_d;
      last_q  <= last_d;
      comp_q  <= comp_d;
      seen_q  <= seen_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q <= pp_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = ov_q;
  assign probably_prime_o = pp_q;

endmodule

// File: sv/miller_rabin_prime_test.sv
// Timing: numbers below 5 pass from the check state straight to the done state; a full round
// is set by the serial shift-add multiplier, with up to two modular multiplies per exponent bit.
// Throughput: one request at a time; the next request is taken in the cycle after a round ends,
// and a last round holds in its final cycle while an earlier result is still stalled.
// Reset (rst_ni low, asynchronous) returns to idle, clears the composite flag, drops any result.
module miller_rabin_prime_test import mrpt_pkg::*; #(
  parameter int unsigned NUMBER_WIDTH = 63
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [NUMBER_WIDTH-1:0] number_i,
  input  logic [RAW_W-1:0]        witness_raw_i,
  input  logic                    last_round_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    probably_prime_o
);

  // Each request is one Miller-Rabin round. The datapath holds the number, the witness
  // remainder, the exponent and the operands of a single shared modular multiplier that
  // adds and doubles one multiplier bit per cycle, every sum exact with one guard bit.
  // The controller sequences the witness reduction (a 31-step restoring division by
  // number - 4), the stripping of twos from number - 1, square-and-multiply, and the
  // final squaring loop that looks for number - 1.
  //
  // The controller also keeps the run's composite flag. A round marked last posts its
  // verdict into an output register and clears the flag; a new request is accepted
  // while that result still waits to be taken.

  dp_cmd_t    cmd;
  dp_status_t status;

  mrpt_dp #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .number_i     (number_i),
    .witness_raw_i(witness_raw_i),
    .cmd_i        (cmd),
    .status_o     (status)
  );

  mrpt_ctrl #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .last_round_i    (last_round_i),
    .in_stall_o      (in_stall_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .probably_prime_o(probably_prime_o),
    .cmd_o           (cmd),
    .status_i        (status)
  );

endmodule

// File: sv/mrpt_checker.sv
module mrpt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic probably_prime_o
);

  // A stalled result stays and keeps its verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(probably_prime_o))
    else $error("stalled result changed");

  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after a request");

  // A new result only appears at the end of a round in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a round in progress");

  // A round never finishes in the cycle right after its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !(out_valid_o && !$past(out_valid_o)))
    else $error("result too early");

endmodule

bind miller_rabin_prime_test mrpt_checker u_mrpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .probably_prime_o(probably_prime_o)
);

// File: sim/testbench.sv
module testbench;
  import mrpt_pkg::*;

  // The width under test is the block's default, so number fits in 63 bits and every
  // modular sum in the predictor fits in 64 bits without wrapping.
  localparam int unsigned NW = 63;

  // The watchdog allows several full rounds' worth of silence, which covers the longest
  // stall and the longest input gap many times over.
  localparam int unsigned WATCHDOG_LIMIT = 60000;
  localparam int unsigned DRAIN_CYCLES   = 8400;
  localparam int unsigned RANDOM_ROUNDS  = 100;

  // How a row of the directed table states its verdict: typed in by hand where it is
  // obvious, or left to the predictor.
  typedef enum logic [1:0] {
    VERDICT_COMPOSITE = 2'd0,
    VERDICT_PRIME     = 2'd1,
    VERDICT_PREDICTED = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [NW-1:0]    number;
    logic [RAW_W-1:0] raw;
    logic             last;
    verdict_e         verdict;
  } round_row_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             in_valid_i    = 1'b0;
  logic             in_stall_o;
  logic [NW-1:0]    number_i      = '0;
  logic [RAW_W-1:0] witness_raw_i = '0;
  logic             last_round_i  = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i   = 1'b0;
  logic             probably_prime_o;

  // Verdicts still owed by the block, oldest first, and the predictor's own copy of
  // the flag that collects composite findings across the rounds of one run.
  bit          verdict_q[$];
  bit          seen_composite = 1'b0;
  bit          calm_run = 1'b0;

  int unsigned errors = 0;
  int unsigned rounds_sent = 0;
  int unsigned verdicts_expected = 0;
  int unsigned verdicts_checked = 0;
  int unsigned primes_seen = 0;
  int unsigned quiet_cycles = 0;

  // Directed rounds: the small numbers that are decided without a witness, the extreme
  // numbers and witness words, an even number, a Carmichael number and strong
  // pseudoprimes that fool the first witnesses, a run whose number changes between
  // rounds, and a run where an early composite round outweighs a later prime one.
  round_row_t directed_rounds [22] = '{
    '{63'd1,                     31'h0000_0000, 1'b1, VERDICT_COMPOSITE},
    '{63'd2,                     31'h7FFF_FFFF, 1'b1, VERDICT_PRIME},
    '{63'd3,                     31'h0000_0000, 1'b1, VERDICT_PRIME},
    '{63'd4,                     31'h7FFF_FFFF, 1'b1, VERDICT_COMPOSITE},
    '{63'd5,                     31'h0000_0000, 1'b0, VERDICT_PREDICTED},
    '{63'd5,                     31'h7FFF_FFFF, 1'b1, VERDICT_PREDICTED},
    '{63'd6,                     31'h0000_0000, 1'b1, VERDICT_PREDICTED},
    '{63'h7FFF_FFFF_FFFF_FFFF,   31'h7FFF_FFFF, 1'b1, VERDICT_PREDICTED},
    '{63'h7FFF_FFFF_FFFF_FFE7,   31'h0000_0000, 1'b0, VERDICT_PREDICTED},
    '{63'h7FFF_FFFF_FFFF_FFE7,   31'h5555_5555, 1'b0, VERDICT_PREDICTED},
    '{63'h7FFF_FFFF_FFFF_FFE7,   31'h7FFF_FFFF, 1'b1, VERDICT_PREDICTED},
    '{63'd561,                   31'h0000_0000, 1'b1, VERDICT_PREDICTED},
    '{63'd2047,                  31'h0000_0000, 1'b1, VERDICT_PREDICTED},
    '{63'd3215031751,            31'h0000_0000, 1'b0, VERDICT_PREDICTED},
    '{63'd3215031751,            31'h0000_0003, 1'b1, VERDICT_PREDICTED},
    '{63'h1FFF_FFFF_FFFF_FFFF,   31'h2AAA_AAAA, 1'b1, VERDICT_PREDICTED},
    '{63'd7,                     31'd12345,     1'b0, VERDICT_PREDICTED},
    '{63'd9,                     31'd12345,     1'b0, VERDICT_PREDICTED},
    '{63'd11,                    31'd12345,     1'b1, VERDICT_PREDICTED},
    '{63'd4,                     31'h0000_0000, 1'b0, VERDICT_PREDICTED},
    '{63'd3,                     31'h0000_0000, 1'b1, VERDICT_COMPOSITE},
    '{63'h4000_0000_0000_0000,   31'd12345,     1'b1, VERDICT_PREDICTED}
  };

  // Pools for the random part: primes up to the top of the range, and composites that
  // are hard to catch (Carmichael numbers, strong pseudoprimes, products of two primes).
  logic [NW-1:0] known_primes [10] = '{
    63'd5, 63'd7, 63'd97, 63'd65537, 63'd2147483647, 63'd1000000007, 63'd4294967291,
    63'd999999999989, 63'h1FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFE7
  };
  logic [NW-1:0] known_composites [10] = '{
    63'd561, 63'd1105, 63'd2047, 63'd1373653, 63'd25326001, 63'd3215031751,
    63'd4294967297, 63'd3825123056546413051, 63'd1000000016000000063,
    63'h7FFF_FFFF_FFFF_FFFF
  };

  miller_rabin_prime_test #(
    .NUMBER_WIDTH(NW)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .number_i        (number_i),
    .witness_raw_i   (witness_raw_i),
    .last_round_i    (last_round_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .probably_prime_o(probably_prime_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Modular arithmetic of the predictor. Operands stay below n < 2^63, so the 64-bit
  // sum never wraps before it is reduced.
  function automatic logic [63:0] addmod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [63:0] s;
    s = a + b;
    return (s >= n) ? s - n : s;
  endfunction

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [63:0] acc;
    acc = '0;
    while (b != 0) begin
      if (b[0]) acc = addmod(acc, a, n);
      a = addmod(a, a, n);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] n);
    logic [63:0] acc;
    acc = 64'd1;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, base, n);
      base = mulmod(base, base, n);
      e = e >> 1;
    end
    return acc;
  endfunction

  // One Miller-Rabin round: 1 when the witness taken from raw proves n composite.
  function automatic bit witness_finds_composite(logic [63:0] n, logic [63:0] raw);
    logic [63:0] odd_part;
    logic [63:0] x;
    int unsigned twos;
    if (n == 64'd0 || n == 64'd1 || n == 64'd4) return 1'b1;
    if (n == 64'd2 || n == 64'd3) return 1'b0;
    odd_part = n - 64'd1;
    twos = 0;
    while (!odd_part[0]) begin
      odd_part = odd_part >> 1;
      twos++;
    end
    x = powmod(raw % (n - 64'd4) + 64'd2, odd_part, n);
    if (x == 64'd1) return 1'b0;
    for (int unsigned j = 0; j < twos; j++) begin
      if (x == n - 64'd1) return 1'b0;
      x = mulmod(x, x, n);
      if (x == 64'd1) return 1'b1;
    end
    return 1'b1;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [NW-1:0] pick_number();
    logic [63:0] w;
    logic [31:0] a;
    logic [31:0] b;
    case ($urandom_range(0, 9))
      0: w = {32'd0, $urandom_range(1, 4)};
      1: w = {32'd0, $urandom_range(5, 200)};
      2, 3: w = {1'b0, known_primes[$urandom_range(0, 9)]};
      4: w = {1'b0, known_composites[$urandom_range(0, 9)]};
      5: begin
        a = $urandom | 32'd1;
        b = $urandom | 32'd1;
        w = {33'd0, a[30:0]} * {33'd0, b[30:0]};
      end
      default: begin
        a = $urandom;
        b = $urandom;
        w = {a, b};
        if ($urandom_range(0, 3) != 0) w[0] = 1'b1;
      end
    endcase
    if (w[NW-1:0] == '0) w = 64'd1;
    return w[NW-1:0];
  endfunction

  // Offers one request after a random gap, or none in a calm run, holds it until the block
  // takes it, and updates the predicted flag at the edge where it is accepted. A verdict
  // is owed only for the last round of a run.
  task automatic send_round(logic [NW-1:0] n, logic [RAW_W-1:0] raw, bit last,
                            verdict_e typed);
    int unsigned gap;
    gap = calm_run ? 0 : idle_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    number_i      <= n;
    witness_raw_i <= raw;
    last_round_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rounds_sent++;
    if (witness_finds_composite({1'b0, n}, {33'd0, raw})) seen_composite = 1'b1;
    if (last) begin
      if (typed == VERDICT_PREDICTED) verdict_q.push_back(!seen_composite);
      else verdict_q.push_back(typed == VERDICT_PRIME);
      seen_composite = 1'b0;
      verdicts_expected++;
    end
  endtask

  // The receiver alternates between open and stalled stretches. Most stalls are short,
  // a few are long, and some open stretches are long enough to let several verdicts
  // through back to back.
  always @(negedge clk_i) begin : stall_gen
    int unsigned stall_left;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 4) begin
      out_stall_i <= 1'b1;
      stall_left  <= idle_gap();
    end else begin
      out_stall_i <= 1'b0;
      stall_left  <= ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                                 : $urandom_range(0, 20);
    end
  end

  // Every verdict the block hands over is matched against the oldest one owed.
  always @(posedge clk_i) begin : verdict_check
    bit want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $error("probably_prime: no verdict expected, got %0b", probably_prime_o);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        verdicts_checked++;
        if (probably_prime_o === 1'b1) primes_seen++;
        if (probably_prime_o !== want) begin
          $error("probably_prime: expected %0b, got %0b", want, probably_prime_o);
          errors++;
        end
      end
    end
  end

  // The run is declared hung when neither side has moved a request for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL miller_rabin_prime_test");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned run_len;
    logic [NW-1:0] n;
    logic [31:0] w32;
    bit mixed;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rounds[i]) begin
      send_round(directed_rounds[i].number, directed_rounds[i].raw,
                 directed_rounds[i].last, directed_rounds[i].verdict);
    end

    // Random runs of one to four rounds on one number. About one run in ten is noise:
    // the number changes from round to round. Some runs offer requests back to back.
    while (rounds_sent < $size(directed_rounds) + RANDOM_ROUNDS) begin
      run_len  = $urandom_range(1, 4);
      n        = pick_number();
      calm_run = ($urandom_range(0, 3) == 0);
      mixed    = ($urandom_range(0, 9) == 0);
      for (int unsigned k = 0; k < run_len; k++) begin
        if (mixed) n = pick_number();
        w32 = $urandom;
        send_round(n, w32[RAW_W-1:0], k == run_len - 1, VERDICT_PREDICTED);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    // A stray verdict could still follow a full round, so keep watching for one.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d rounds (%0d directed), checked %0d of %0d verdicts, %0d of them prime.",
             rounds_sent, $size(directed_rounds), verdicts_checked, verdicts_expected,
             primes_seen);
    $display("Numbers ranged over small cases, even values, pseudoprimes and 63-bit values.");
    if (errors == 0) begin
      $display("PASS miller_rabin_prime_test");
    end else begin
      $display("FAIL miller_rabin_prime_test");
    end
    $finish;
  end

endmodule

// File: miller_rabin_prime_test.f
sv/mrpt_pkg.sv
sv/mrpt_dp.sv
sv/mrpt_ctrl.sv
sv/miller_rabin_prime_test.sv
sv/mrpt_checker.sv
sim/testbench.sv
